@@ rtl/msort_pkg.sv @@
// msort_pkg: shared types and default sizes for the merge sorter.
// Used by every module and interface of the block; no dependencies.
`timescale 1ns / 1ps

package msort_pkg;

  localparam int DataW            = 32;
  localparam int MaxItemsDefault  = 64;
  localparam int FifoDepthDefault = 4;

  // One classified input item as it travels from the front to the back.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    is_final;
    logic                    keep;   // there was room for it in the buffer
    logic                    ovf;    // block has dropped an element so far
  } msort_entry_t;

  // Phase of the back end, seen by the top level.
  typedef struct packed {
    logic loading;
    logic sorting;
    logic emitting;
  } msort_status_t;

endpackage

@@ rtl/msort_in_if.sv @@
// msort_in_if: input channel of the merge sorter (valid/ready plus item fields).
// Depends on msort_pkg.
`timescale 1ns / 1ps

interface msort_in_if import msort_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] value;
  logic                    is_final;

  modport source (output valid, value, is_final, input ready);
  modport sink   (input valid, value, is_final, output ready);
endinterface

@@ rtl/msort_out_if.sv @@
// msort_out_if: result channel of the merge sorter (valid/ready plus result fields).
// Depends on msort_pkg.
`timescale 1ns / 1ps

interface msort_out_if import msort_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] sorted_value;
  logic                    end_of_run;
  logic                    overflow;

  modport source (output valid, sorted_value, end_of_run, overflow, input ready);
  modport sink   (input valid, sorted_value, end_of_run, overflow, output ready);
endinterface

@@ rtl/msort_front.sv @@
// msort_front: accepts input items, tracks block fill and overflow, tags each item.
// Depends on msort_pkg and msort_in_if.
`timescale 1ns / 1ps

module msort_front import msort_pkg::*; #(
  parameter int MAX_ITEMS = MaxItemsDefault
) (
  input  logic          clk,
  input  logic          rst,
  msort_in_if.sink      items,
  output logic          push_valid,
  input  logic          push_ready,
  output msort_entry_t  push_data
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] Full = CW'(MAX_ITEMS);

  logic [CW-1:0] count;
  logic          ovf_seen;
  logic          keep;
  logic          take;

  assign items.ready = push_ready;
  assign take        = items.valid & push_ready;
  assign keep        = (count != Full);
  assign push_valid  = items.valid;

  always_comb begin
    push_data.value    = items.value;
    push_data.is_final = items.is_final;
    push_data.keep     = keep;
    push_data.ovf      = ovf_seen | ~keep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf_seen <= 1'b0;
    end else if (take) begin
      if (items.is_final) begin
        count    <= '0;
        ovf_seen <= 1'b0;
      end else if (keep) begin
        count <= count + 1'b1;
      end else begin
        ovf_seen <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/msort_fifo.sv @@
// msort_fifo: short queue of classified items between front and back.
// Depends on msort_pkg.
`timescale 1ns / 1ps

module msort_fifo import msort_pkg::*; #(
  parameter int DEPTH = FifoDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  msort_entry_t  push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output msort_entry_t  pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [FW-1:0] FullCnt = FW'(DEPTH);

  msort_entry_t  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          push;
  logic          pop;

  assign push_ready = (fill != FullCnt);
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/msort_back.sv @@
// msort_back: loads a block into buffer_a, merge sorts it bottom-up over
// buffer_a/buffer_b and emits the sorted values. Depends on msort_pkg, msort_out_if.
`timescale 1ns / 1ps

module msort_back import msort_pkg::*; #(
  parameter int MAX_ITEMS = MaxItemsDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  msort_entry_t   pop_data,
  msort_out_if.source    results,
  output msort_status_t  status
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int WW = CW + 2;

  typedef enum logic [2:0] {
    LOAD, MERGE_RD, MERGE_WR, EMIT_RD, EMIT_LOAD, EMIT_HOLD
  } state_t;

  state_t state;

  logic [DataW-1:0] buffer_a [MAX_ITEMS];
  logic [DataW-1:0] buffer_b [MAX_ITEMS];
  logic [DataW-1:0] rd_a0, rd_a1, rd_b0, rd_b1;

  logic [CW-1:0] n;       // elements in block (load counter while loading)
  logic [CW-1:0] i;       // left run cursor, emit cursor
  logic [CW-1:0] j;       // right run cursor
  logic [CW-1:0] k;       // merge output cursor
  logic [CW-1:0] mid;
  logic [CW-1:0] hi;
  logic [CW-1:0] width;
  logic          src_sel; // 0: buffer_a holds the current runs
  logic          ovf_blk;

  logic                    out_valid;
  logic signed [DataW-1:0] out_value;
  logic                    out_end;
  logic                    out_ovf;

  // write port muxing
  logic             wr_a, wr_b;
  logic [AW-1:0]    wr_addr;
  logic [DataW-1:0] wr_data;

  logic                    pop_fire;
  logic [CW-1:0]           n_final;
  logic signed [DataW-1:0] left_v, right_v;
  logic                    take_left;
  logic                    run_end, pass_end;
  logic [WW-1:0]           n_w, w_w, w2_w, hi_w;
  logic [WW-1:0]           nx_mid_w, nx_hi_w, p_mid_w, p_hi_w;
  logic                    last_pass;

  assign pop_ready = (state == LOAD);
  assign pop_fire  = pop_valid & pop_ready;
  assign n_final   = n + CW'(pop_data.keep);

  assign left_v    = $signed(src_sel ? rd_b0 : rd_a0);
  assign right_v   = $signed(src_sel ? rd_b1 : rd_a1);
  assign take_left = (i < mid) && ((j >= hi) || (left_v < right_v));
  assign run_end   = ((k + 1'b1) == hi);
  assign pass_end  = (hi == n);

  // run bounds for the next run of this pass and the first run of the next pass
  always_comb begin
    n_w      = WW'(n);
    w_w      = WW'(width);
    w2_w     = w_w << 1;
    hi_w     = WW'(hi);
    nx_mid_w = hi_w + w_w;
    nx_hi_w  = hi_w + w2_w;
    p_mid_w  = w2_w;
    p_hi_w   = w2_w << 1;
    if (nx_mid_w > n_w) nx_mid_w = n_w;
    if (nx_hi_w > n_w)  nx_hi_w  = n_w;
    if (p_mid_w > n_w)  p_mid_w  = n_w;
    if (p_hi_w > n_w)   p_hi_w   = n_w;
    last_pass = (w2_w >= n_w);
  end

  always_comb begin
    wr_a    = 1'b0;
    wr_b    = 1'b0;
    wr_addr = k[AW-1:0];
    wr_data = take_left ? left_v : right_v;
    if (state == LOAD) begin
      wr_a    = pop_fire & pop_data.keep;
      wr_addr = n[AW-1:0];
      wr_data = pop_data.value;
    end else if (state == MERGE_WR) begin
      wr_a = src_sel;
      wr_b = ~src_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      buffer_a[wr_addr] <= wr_data;
    end
    rd_a0 <= buffer_a[i[AW-1:0]];
    rd_a1 <= buffer_a[j[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      buffer_b[wr_addr] <= wr_data;
    end
    rd_b0 <= buffer_b[i[AW-1:0]];
    rd_b1 <= buffer_b[j[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      n         <= '0;
      out_valid <= 1'b0;
      src_sel   <= 1'b0;
      ovf_blk   <= 1'b0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      mid       <= '0;
      hi        <= '0;
      width     <= '0;
    end else begin
      unique case (state)
        LOAD: begin
          if (pop_fire) begin
            n <= n_final;
            if (pop_data.is_final) begin
              ovf_blk <= pop_data.ovf;
              src_sel <= 1'b0;
              i       <= '0;
              if (n_final == CW'(1)) begin
                state <= EMIT_RD;
              end else begin
                width <= CW'(1);
                j     <= CW'(1);
                mid   <= CW'(1);
                hi    <= (n_final == CW'(2)) ? CW'(2) : CW'(2);
                k     <= '0;
                state <= MERGE_RD;
              end
            end
          end
        end
        MERGE_RD: begin
          state <= MERGE_WR;
        end
        MERGE_WR: begin
          state <= MERGE_RD;
          if (take_left) i <= i + 1'b1;
          else           j <= j + 1'b1;
          k <= k + 1'b1;
          if (run_end) begin
            if (pass_end) begin
              src_sel <= ~src_sel;
              i       <= '0;
              if (last_pass) begin
                state <= EMIT_RD;
              end else begin
                width <= w2_w[CW-1:0];
                mid   <= p_mid_w[CW-1:0];
                j     <= p_mid_w[CW-1:0];
                hi    <= p_hi_w[CW-1:0];
                k     <= '0;
              end
            end else begin
              i   <= hi;
              mid <= nx_mid_w[CW-1:0];
              j   <= nx_mid_w[CW-1:0];
              hi  <= nx_hi_w[CW-1:0];
            end
          end
        end
        EMIT_RD: begin
          state <= EMIT_LOAD;
        end
        EMIT_LOAD: begin
          out_value <= left_v;
          out_end   <= ((i + 1'b1) == n);
          out_ovf   <= ovf_blk;
          out_valid <= 1'b1;
          state     <= EMIT_HOLD;
        end
        EMIT_HOLD: begin
          if (results.ready) begin
            out_valid <= 1'b0;
            if (out_end) begin
              n     <= '0;
              state <= LOAD;
            end else begin
              i     <= i + 1'b1;
              state <= EMIT_RD;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  assign results.valid        = out_valid;
  assign results.sorted_value = out_value;
  assign results.end_of_run   = out_end;
  assign results.overflow     = out_ovf;

  always_comb begin
    status.loading  = (state == LOAD);
    status.sorting  = (state == MERGE_RD) || (state == MERGE_WR);
    status.emitting = (state == EMIT_RD) || (state == EMIT_LOAD) || (state == EMIT_HOLD);
  end

endmodule

@@ rtl/merge_sorter_unit.sv @@
// merge_sorter_unit: block merge sorter, signed 32-bit keys, ascending, ties right-first.
// Load: one transfer per cycle into a 4-entry queue while it has room, drained into buffer_a at one per cycle in LOAD.
// Sort: ceil(log2 n) passes; per element per pass a registered buffer read (MERGE_RD), then a write (MERGE_WR).
// Emit: each result is read (EMIT_RD), registered (EMIT_LOAD) and held (EMIT_HOLD) until ready.
// The front keeps taking items into the queue while the back sorts or emits, until the queue is full.
// Reset (rst, synchronous, active high) empties queue and counters; buffers are not cleared.
`timescale 1ns / 1ps

module merge_sorter_unit import msort_pkg::*; #(
  parameter int MAX_ITEMS  = MaxItemsDefault,
  parameter int FIFO_DEPTH = FifoDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  msort_in_if.sink    items,
  msort_out_if.source results
);

  // classified items between front and back
  logic          push_valid;
  logic          push_ready;
  msort_entry_t  push_data;
  logic          pop_valid;
  logic          pop_ready;
  msort_entry_t  pop_data;
  msort_status_t status;

  // Front: counts the block, flags elements past MAX_ITEMS so that the back drops them.
  msort_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue: lets input transfers continue while the back end is busy.
  msort_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: load, bottom-up merge passes over the ping-pong buffers, emit.
  msort_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .results   (results),
    .status    (status)
  );

  // back end is in exactly one phase
  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot({status.loading, status.sorting, status.emitting}))
    else $error("back end phase not one-hot");

  // no result is shown while merge passes run
  a_quiet_sort: assert property (@(posedge clk) disable iff (rst)
    status.sorting |-> !results.valid)
    else $error("result valid during merge");

  // after the last result of a block the back end returns to loading
  a_block_close: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ready && results.end_of_run |=> status.loading && !results.valid)
    else $error("block did not close after final transfer");

  // the queue drains only into the loader
  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop_valid && pop_ready |-> status.loading)
    else $error("queue popped outside load phase");

endmodule

@@ sim/testbench.sv @@
// testbench: self-checking bench for merge_sorter_unit; blocks of signed 32-bit values
// go in, sorted runs come out. Depends on msort_pkg, msort_in_if, msort_out_if and the RTL.
`timescale 1ns / 1ps

module testbench;
  import msort_pkg::*;

  localparam int BlockCap     = MaxItemsDefault;  // elements one block can hold
  localparam int ItemTarget   = 330;              // input transfers before random blocks stop
  localparam int QuietLimit   = 6000;             // cycles with no transfer before giving up
  localparam int SettleCycles = 64;               // watch for stray results at the end

  // One expected sorted element.
  typedef struct {
    logic signed [DataW-1:0] sorted_value;
    logic                    end_of_run;
    logic                    overflow;
  } sorted_entry_t;

  typedef enum logic {SINK_FREE, SINK_PATTERN} sink_mode_t;
  typedef enum int {MIX_FULL, MIX_NARROW, MIX_EXTREME} value_mix_t;
  typedef enum int {ORDER_SHUFFLED, ORDER_RISING, ORDER_FALLING} block_order_t;

  logic clk = 1'b0;
  logic rst;

  always #4 clk = ~clk;

  msort_in_if  elem_ch ();
  msort_out_if sorted_ch ();

  merge_sorter_unit #(
    .MAX_ITEMS(BlockCap)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (elem_ch.sink),
    .results (sorted_ch.source)
  );

  // ---------------------------------------------------------------------------
  // Sorter model: its own load buffer, count and drop flag. Every accepted
  // element goes through load_element; a block end queues its sorted run.
  // ---------------------------------------------------------------------------
  logic signed [DataW-1:0] held_vals [BlockCap];
  logic [6:0]              held_count    = '0;
  logic                    dropped_seen  = 1'b0;
  sorted_entry_t           expected_sorted [$];

  int elements_sent   = 0;
  int blocks_sorted   = 0;
  int overflow_blocks = 0;
  int largest_block   = 0;
  int results_checked = 0;
  int mismatch_count  = 0;

  // Bottom-up merge over two buffers; the left run wins only when strictly
  // smaller, so equal keys come from the right run first.
  function automatic void merge_sort_held(input int n);
    logic signed [DataW-1:0] src [BlockCap];
    logic signed [DataW-1:0] dst [BlockCap];
    int w, lo, mid, hi, i, j, k;
    src = held_vals;
    dst = held_vals;
    for (w = 1; w < n; w = w * 2) begin
      for (lo = 0; lo < n; lo = lo + 2 * w) begin
        mid = (lo + w > n) ? n : lo + w;
        hi  = (lo + 2 * w > n) ? n : lo + 2 * w;
        i   = lo;
        j   = mid;
        for (k = lo; k < hi; k++) begin
          if (i < mid && (j >= hi || src[i] < src[j])) begin
            dst[k] = src[i];
            i++;
          end else begin
            dst[k] = src[j];
            j++;
          end
        end
      end
      src = dst;
    end
    held_vals = src;
  endfunction

  function automatic void load_element(input logic signed [DataW-1:0] v, input logic is_last);
    sorted_entry_t e;
    int n;
    if (held_count < BlockCap) begin
      held_vals[held_count] = v;
      held_count++;
    end else begin
      dropped_seen = 1'b1;   // buffer full: element is lost, block is flagged
    end
    if (is_last) begin
      n = held_count;
      merge_sort_held(n);
      for (int k = 0; k < n; k++) begin
        e.sorted_value = held_vals[k];
        e.end_of_run   = (k == n - 1);
        e.overflow     = dropped_seen;
        expected_sorted.push_back(e);
      end
      blocks_sorted++;
      if (dropped_seen) overflow_blocks++;
      if (n > largest_block) largest_block = n;
      held_count   = '0;
      dropped_seen = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checker.
  // ---------------------------------------------------------------------------
  sink_mode_t  sink_mode   = SINK_FREE;
  logic [15:0] stall_mask  = '0;
  logic [5:0]  stall_phase = '0;

  // The mask is redrawn whenever stall_phase wraps to zero; in SINK_PATTERN mode a set bit stalls for that cycle.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    if (stall_phase == '0) stall_mask <= 16'($urandom);
    sorted_ch.ready <= (sink_mode == SINK_FREE) || !stall_mask[stall_phase[3:0]];
  end

  // Every transfer on the result side is matched against the oldest expectation.
  always @(posedge clk) begin
    sorted_entry_t want;
    if (!rst && sorted_ch.valid && sorted_ch.ready) begin
      if (expected_sorted.size() == 0) begin
        $error("unexpected result: sorted_value %0d, end_of_run %0b, overflow %0b",
               sorted_ch.sorted_value, sorted_ch.end_of_run, sorted_ch.overflow);
        mismatch_count++;
      end else begin
        want = expected_sorted.pop_front();
        results_checked++;
        if (sorted_ch.sorted_value !== want.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                 sorted_ch.sorted_value);
          mismatch_count++;
        end
        if (sorted_ch.end_of_run !== want.end_of_run) begin
          $error("end_of_run: expected %0b, got %0b", want.end_of_run, sorted_ch.end_of_run);
          mismatch_count++;
        end
        if (sorted_ch.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, sorted_ch.overflow);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a long stretch with no transfer on either side ends the run.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (elem_ch.valid && elem_ch.ready) || (sorted_ch.valid && sorted_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. send_element is always entered right after a rising edge and
  // returns right after the edge that took the transfer, with valid still up;
  // the next call either reloads it in the same step or drops it for a gap.
  // ---------------------------------------------------------------------------
  int   burst_left   = 0;
  logic idle_enabled = 1'b1;

  task automatic send_element(input logic signed [DataW-1:0] v, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (idle_enabled && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        elem_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    elem_ch.valid    <= 1'b1;
    elem_ch.value    <= v;
    elem_ch.is_final <= is_last;
    do @(posedge clk); while (!elem_ch.ready);
    load_element(v, is_last);
    elements_sent++;
  endtask

  task automatic stop_sending();
    elem_ch.valid    <= 1'b0;
    elem_ch.is_final <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  // Sender holds off until every queued result has been checked.
  task automatic hold_until_drained();
    stop_sending();
    while (expected_sorted.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DataW-1:0] random_value(input value_mix_t mix);
    logic signed [DataW-1:0] r;
    case (mix)
      MIX_NARROW: begin
        r = $urandom_range(0, 8);        // many equal keys
        r = r - 32'sd4;
      end
      MIX_EXTREME: begin
        r = $urandom_range(0, 3);
        r = $urandom_range(0, 1) ? 32'sh80000000 + r : 32'sh7FFFFFFF - r;
      end
      default: r = $urandom;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Both ends of the range, zero, +/-1, with repeated extremes.
  task automatic test_corner_values();
    logic signed [DataW-1:0] corners [7];
    corners = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, -32'sd1, 32'sd1,
                32'sh7FFFFFFF, 32'sh80000000};
    idle_enabled = 1'b1;
    sink_mode   <= SINK_PATTERN;
    foreach (corners[k]) send_element(corners[k], k == 6);
    stop_sending();
  endtask

  // Single-element block, then pairs: falling, equal, rising.
  task automatic test_tiny_blocks();
    send_element(32'sd77, 1'b1);
    send_element(32'sd5, 1'b0);
    send_element(-32'sd5, 1'b1);
    send_element(32'sd9, 1'b0);
    send_element(32'sd9, 1'b1);
    send_element(-32'sd3, 1'b0);
    send_element(32'sd12, 1'b1);
    stop_sending();
  endtask

  // Alternating bit patterns, back to back with the sink always ready.
  task automatic test_bit_patterns();
    idle_enabled = 1'b0;
    sink_mode   <= SINK_FREE;
    send_element(32'sh55555555, 1'b0);
    send_element(32'shAAAAAAAA, 1'b0);
    send_element(32'shFFFFFFFF, 1'b0);
    send_element(32'sh00000000, 1'b1);
    stop_sending();
  endtask

  // Exactly full block; then two past capacity so the final element itself
  // is dropped; then a short block to see the overflow flag cleared.
  task automatic test_capacity();
    idle_enabled = 1'b1;
    sink_mode   <= SINK_PATTERN;
    for (int k = 0; k < BlockCap; k++) send_element(random_value(MIX_FULL), k == BlockCap - 1);
    for (int k = 0; k < BlockCap + 2; k++) begin
      send_element(random_value(MIX_NARROW), k == BlockCap + 1);
    end
    for (int k = 0; k < 3; k++) send_element(random_value(MIX_EXTREME), k == 2);
    stop_sending();
  endtask

  // Random blocks, mostly short, now and then near, at or past capacity, with
  // shuffled, rising or falling content and changing idle behavior.
  task automatic test_random_blocks();
    logic signed [DataW-1:0] block_vals [$];
    int n;
    value_mix_t mix;
    block_order_t order;
    while (elements_sent < ItemTarget) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(BlockCap - 4, BlockCap + 6)
                                        : $urandom_range(1, 12);
      mix   = value_mix_t'($urandom_range(0, 2));
      order = block_order_t'($urandom_range(0, 2));
      block_vals.delete();
      for (int k = 0; k < n; k++) block_vals.push_back(random_value(mix));
      if (order == ORDER_RISING) block_vals.sort();
      else if (order == ORDER_FALLING) block_vals.rsort();
      idle_enabled = ($urandom_range(0, 3) != 0);
      sink_mode   <= ($urandom_range(0, 2) == 0) ? SINK_FREE : SINK_PATTERN;
      for (int k = 0; k < n; k++) send_element(block_vals[k], k == n - 1);
    end
    stop_sending();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              <= 1'b1;
    elem_ch.valid    <= 1'b0;
    elem_ch.value    <= '0;
    elem_ch.is_final <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_corner_values();
    test_tiny_blocks();
    test_bit_patterns();
    hold_until_drained();
    test_capacity();
    test_random_blocks();

    hold_until_drained();
    repeat (SettleCycles) @(posedge clk);

    $display("Sorted %0d blocks from %0d input transfers, %0d results checked;",
             blocks_sorted, elements_sent, results_checked);
    $display("largest block %0d elements, %0d blocks hit the capacity limit.",
             largest_block, overflow_blocks);
    if (mismatch_count == 0 && expected_sorted.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
